// File: rtl/core/spimbs_pkg.sv
// shared types and constants for the spi master byte shifter
package spimbs_pkg;

	localparam int BITS_PER_WORD = 8;
	localparam int IDX_W         = $clog2(BITS_PER_WORD);
	localparam int HSTEP_W       = $clog2(2 * BITS_PER_WORD);
	localparam int HALF_W        = 16;
	localparam int BYTE_W        = 8;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPI_MODE    = 2'd0,
		REG_LSB_FIRST   = 2'd1,
		REG_HALF_PERIOD = 2'd2
	} cfg_reg_t;

	// one request as held in the input register
	typedef struct packed {
		logic              command;
		logic [BYTE_W-1:0] tx_byte;
		logic              last_byte;
		logic              miso_level;
	} req_t;

	// one result as held in the output register
	typedef struct packed {
		logic              sck_level;
		logic              mosi_level;
		logic [BYTE_W-1:0] rx_byte;
		logic              rx_valid;
		logic              transfer_done;
		logic              busy_res;
		logic              rejected;
	} res_t;

endpackage

// File: rtl/core/spi_master_byte_shifter_top.sv
// spi master byte shifter, modes 0 to 3, msb or lsb first
//
// usage
//   input channel (in_valid / in_ready): each request is either a load
//   (command 0, with tx_byte and last_byte) or a time tick (command 1,
//   carrying the sampled miso_level). every request gives exactly one result
//   on the output channel (out_valid / out_ready) with the line levels after
//   it, rx_byte / rx_valid when a byte completes, transfer_done for a byte
//   marked last, busy_res, and rejected for a load that arrived while busy.
//   config channel (cfg_valid / cfg_ready, always ready): cfg_index 0 spi
//   mode, 1 lsb_first, 2 half_period; other indexes are ignored.
//   path: a request is held in the input register, then its result in the
//   result register, which drives the output channel. throughput: one
//   request per clock while out_ready does not stall, set by the single pass
//   through the shifter logic.
//   stalls: when out_ready is low the result register holds, the input
//   register fills, then in_ready drops; nothing is lost or repeated.
//   reset: mode 0, msb first, half_period 1, shifter idle, sck low, all
//   channels empty.
module spi_master_byte_shifter_top
	import spimbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// config write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [BYTE_W-1:0]     tx_byte,
	input  logic                  last_byte,
	input  logic                  miso_level,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  sck_level,
	output logic                  mosi_level,
	output logic [BYTE_W-1:0]     rx_byte,
	output logic                  rx_valid,
	output logic                  transfer_done,
	output logic                  busy_res,
	output logic                  rejected
);

	// configuration registers
	logic [1:0]        spi_mode_q;
	logic              lsb_first_q;
	logic [HALF_W-1:0] half_period_q;

	// input register
	logic v_s1;
	req_t req_s1;

	// result register
	logic v_s2;
	res_t res_s2;

	// shifter state
	logic [BITS_PER_WORD-1:0] tx_shift_q, tx_shift_d;
	logic [BITS_PER_WORD-1:0] rx_shift_q, rx_shift_d;
	logic [HSTEP_W-1:0]       half_step_q, half_step_d;
	logic [HALF_W-1:0]        tick_count_q, tick_count_d;
	logic                     active_q, active_d;
	logic                     final_q, final_d;
	logic                     clock_q, clock_d;
	logic                     data_q, data_d;
	res_t                     res_d;

	// handshake: result register moves when empty or taken
	logic adv;
	assign adv       = !v_s2 || out_ready;
	assign in_ready  = !v_s1 || adv;
	assign cfg_ready = 1'b1;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spi_mode_q    <= 2'd0;
			lsb_first_q   <= 1'b0;
			half_period_q <= HALF_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SPI_MODE:    spi_mode_q    <= cfg_data[1:0];
				REG_LSB_FIRST:   lsb_first_q   <= cfg_data[0];
				REG_HALF_PERIOD: half_period_q <= cfg_data[HALF_W-1:0];
				default:         ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1.command    <= command;
			req_s1.tx_byte    <= tx_byte;
			req_s1.last_byte  <= last_byte;
			req_s1.miso_level <= miso_level;
		end
	end

	// shifter logic for the request in the input register
	logic              idle_lvl, act_lvl, trailing;
	logic [HALF_W:0]   tick_next;
	logic [IDX_W-1:0]  idx, idx_next;
	logic [IDX_W-1:0]  pos_cur, pos_next, pos_first;
	logic              last_bit;

	// map a bit number of the word to its position in the shift register
	function automatic logic [IDX_W-1:0] bit_pos(input logic lsb, input logic [IDX_W-1:0] n);
		logic [IDX_W-1:0] r;
		r = lsb ? n : (IDX_W'(BITS_PER_WORD - 1) - n);
		return r;
	endfunction

	always_comb begin
		idle_lvl  = spi_mode_q[1];
		act_lvl   = ~spi_mode_q[1];
		trailing  = spi_mode_q[0];
		tick_next = {1'b0, tick_count_q} + (HALF_W+1)'(1);
		idx       = half_step_q[HSTEP_W-1:1];
		idx_next  = idx + IDX_W'(1);
		last_bit  = (idx == IDX_W'(BITS_PER_WORD - 1));
		pos_cur   = bit_pos(lsb_first_q, idx);
		pos_next  = bit_pos(lsb_first_q, idx_next);
		pos_first = bit_pos(lsb_first_q, IDX_W'(0));

		tx_shift_d   = tx_shift_q;
		rx_shift_d   = rx_shift_q;
		half_step_d  = half_step_q;
		tick_count_d = tick_count_q;
		active_d     = active_q;
		final_d      = final_q;
		clock_d      = active_q ? clock_q : idle_lvl;
		data_d       = data_q;

		res_d          = '0;

		if (req_s1.command == CMD_LOAD) begin
			if (active_q) begin
				res_d.rejected = 1'b1;
			end else begin
				tx_shift_d   = BITS_PER_WORD'(req_s1.tx_byte);
				final_d      = req_s1.last_byte;
				rx_shift_d   = '0;
				half_step_d  = '0;
				tick_count_d = '0;
				active_d     = 1'b1;
				data_d       = tx_shift_d[pos_first];
				clock_d      = trailing ? act_lvl : idle_lvl;
			end
		end else if (active_q) begin
			if (tick_next >= {1'b0, half_period_q}) begin
				tick_count_d = '0;
				if (!half_step_q[0]) begin
					// sampling edge
					clock_d = trailing ? idle_lvl : act_lvl;
					if (req_s1.miso_level) begin
						rx_shift_d[pos_cur] = 1'b1;
					end
					half_step_d = half_step_q + HSTEP_W'(1);
				end else if (last_bit) begin
					// word complete
					clock_d             = idle_lvl;
					active_d            = 1'b0;
					half_step_d         = '0;
					res_d.rx_valid      = 1'b1;
					res_d.transfer_done = final_q;
					res_d.rx_byte       = BYTE_W'(rx_shift_q);
				end else begin
					// shift edge, next bit onto mosi
					clock_d     = trailing ? act_lvl : idle_lvl;
					data_d      = tx_shift_q[pos_next];
					half_step_d = half_step_q + HSTEP_W'(1);
				end
			end else begin
				tick_count_d = tick_next[HALF_W-1:0];
			end
		end

		res_d.sck_level  = clock_d;
		res_d.mosi_level = data_d;
		res_d.busy_res   = active_d;
	end

	logic step;
	assign step = v_s1 && adv;

	// shifter state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_shift_q   <= '0;
			rx_shift_q   <= '0;
			half_step_q  <= '0;
			tick_count_q <= '0;
			active_q     <= 1'b0;
			final_q      <= 1'b0;
			clock_q      <= 1'b0;
			data_q       <= 1'b0;
		end else if (step) begin
			tx_shift_q   <= tx_shift_d;
			rx_shift_q   <= rx_shift_d;
			half_step_q  <= half_step_d;
			tick_count_q <= tick_count_d;
			active_q     <= active_d;
			final_q      <= final_d;
			clock_q      <= clock_d;
			data_q       <= data_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid     = v_s2;
	assign sck_level     = res_s2.sck_level;
	assign mosi_level    = res_s2.mosi_level;
	assign rx_byte       = res_s2.rx_byte;
	assign rx_valid      = res_s2.rx_valid;
	assign transfer_done = res_s2.transfer_done;
	assign busy_res      = res_s2.busy_res;
	assign rejected      = res_s2.rejected;

endmodule

// File: rtl/core/spimbs_checker.sv
// port level checks for the spi master byte shifter, with its bind
module spimbs_checker
	import spimbs_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [BYTE_W-1:0] rx_byte,
	input logic              rx_valid,
	input logic              transfer_done,
	input logic              busy_res,
	input logic              rejected
);

	// a finished byte leaves the shifter idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_valid |-> !busy_res)
		else $error("byte completed while still busy");

	// transfer end only comes with a received byte
	a_done_rx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && transfer_done |-> rx_valid)
		else $error("transfer_done without rx_valid");

	// a rejected load only happens while busy, and leaves it busy
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res && !rx_valid)
		else $error("rejected load while idle");

	// no received data without a completed byte
	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rx_valid |-> rx_byte == '0)
		else $error("rx_byte nonzero without rx_valid");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rx_byte) && $stable(busy_res))
		else $error("stalled result changed");

endmodule

bind spi_master_byte_shifter_top spimbs_checker u_spimbs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.rx_byte       (rx_byte),
	.rx_valid      (rx_valid),
	.transfer_done (transfer_done),
	.busy_res      (busy_res),
	.rejected      (rejected)
);

// File: dv/spi_master_byte_shifter_top_tb.sv
// self-checking testbench for the spi master byte shifter: random requests, predicted line levels
`timescale 1ns / 100ps

module spi_master_byte_shifter_top_tb
	import spimbs_pkg::*;
();

	// index with no register behind it, the block must ignore writes to it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned RANDOM_REQUESTS = 1000;
	// margin waited after the last result has come back
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned MAX_REPORTS = 10;

	// tracks the shifter state and holds the line levels each request must produce
	class spi_shift_tracker;
		logic [1:0]               spi_mode;
		logic                     lsb_first;
		logic [CFG_DATA_W-1:0]    half_period;
		logic [BITS_PER_WORD-1:0] tx_shift;
		logic [BITS_PER_WORD-1:0] rx_shift;
		int unsigned              half_step;
		int unsigned              tick_count;
		logic                     active;
		logic                     final_flag;
		logic                     clock_out;
		logic                     data_out;
		res_t                     pending_lines[$];
		int unsigned              failures;

		function new();
			spi_mode    = 2'd0;
			lsb_first   = 1'b0;
			half_period = 16'd1;
			tx_shift    = '0;
			rx_shift    = '0;
			half_step   = 0;
			tick_count  = 0;
			active      = 1'b0;
			final_flag  = 1'b0;
			clock_out   = 1'b0;
			data_out    = 1'b0;
			failures    = 0;
		endfunction

		function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SPI_MODE:    spi_mode = data[1:0];
				REG_LSB_FIRST:   lsb_first = data[0];
				REG_HALF_PERIOD: half_period = data;
				default: ;
			endcase
		endfunction

		function int unsigned word_bit(int unsigned idx);
			return lsb_first ? idx : BITS_PER_WORD - 1 - idx;
		endfunction

		// returns 1 when the request moved the shifter (ignored requests return 0)
		function bit note_request(req_t req);
			logic        idle_lvl;
			logic        act_lvl;
			logic        trailing;
			int unsigned idx;
			bit          effective;
			res_t        want;
			idle_lvl  = spi_mode[1];
			act_lvl   = ~idle_lvl;
			trailing  = spi_mode[0];
			want      = '0;
			effective = 1'b0;
			if (!active)
				clock_out = idle_lvl;
			if (req.command == CMD_LOAD) begin
				if (active) begin
					want.rejected = 1'b1;
				end else begin
					tx_shift   = req.tx_byte;
					final_flag = req.last_byte;
					rx_shift   = '0;
					half_step  = 0;
					tick_count = 0;
					active     = 1'b1;
					data_out   = tx_shift[word_bit(0)];
					clock_out  = trailing ? act_lvl : idle_lvl;
					effective  = 1'b1;
				end
			end else if (active) begin
				effective = 1'b1;
				if (tick_count + 1 >= half_period) begin
					idx        = half_step >> 1;
					tick_count = 0;
					if (half_step[0] == 1'b0) begin
						// first half of a bit: sampling edge in every mode
						clock_out = trailing ? idle_lvl : act_lvl;
						if (req.miso_level)
							rx_shift[word_bit(idx)] = 1'b1;
						half_step++;
					end else if (idx + 1 >= BITS_PER_WORD) begin
						clock_out          = idle_lvl;
						active             = 1'b0;
						half_step          = 0;
						want.rx_valid      = 1'b1;
						want.transfer_done = final_flag;
						want.rx_byte       = rx_shift;
					end else begin
						clock_out = trailing ? act_lvl : idle_lvl;
						data_out  = tx_shift[word_bit(idx + 1)];
						half_step++;
					end
				end else begin
					tick_count++;
				end
			end
			want.sck_level  = clock_out;
			want.mosi_level = data_out;
			want.busy_res   = active;
			pending_lines.push_back(want);
			return effective;
		endfunction

		function string show(res_t lines);
			return $sformatf("sck=%0b mosi=%0b rx=%02h rx_valid=%0b done=%0b busy=%0b rej=%0b",
				lines.sck_level, lines.mosi_level, lines.rx_byte, lines.rx_valid,
				lines.transfer_done, lines.busy_res, lines.rejected);
		endfunction

		function void note_failure(string what, res_t want, res_t seen);
			if (failures < MAX_REPORTS)
				$display("%0t %s: exp %s got %s", $time, what, show(want), show(seen));
			failures++;
		endfunction

		function void check_result(res_t seen);
			res_t want;
			if (pending_lines.size() == 0) begin
				note_failure("result with no request outstanding", '0, seen);
				return;
			end
			want = pending_lines.pop_front();
			if (seen.sck_level !== want.sck_level || seen.mosi_level !== want.mosi_level ||
			    seen.rx_byte !== want.rx_byte || seen.rx_valid !== want.rx_valid ||
			    seen.transfer_done !== want.transfer_done ||
			    seen.busy_res !== want.busy_res || seen.rejected !== want.rejected)
				note_failure("result mismatch", want, seen);
		endfunction

		function void close_out();
			if (pending_lines.size() != 0) begin
				if (failures < MAX_REPORTS)
					$display("%0t %0d results never arrived", $time, pending_lines.size());
				failures += pending_lines.size();
			end
		endfunction

		function int unsigned pending();
			return pending_lines.size();
		endfunction

		function bit shifting();
			return active;
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  command;
	logic [BYTE_W-1:0]     tx_byte;
	logic                  last_byte;
	logic                  miso_level;
	logic                  out_valid;
	logic                  out_ready;
	logic                  sck_level;
	logic                  mosi_level;
	logic [BYTE_W-1:0]     rx_byte;
	logic                  rx_valid;
	logic                  transfer_done;
	logic                  busy_res;
	logic                  rejected;

	spi_shift_tracker tracker = new();
	// sender burst bookkeeping and the count of requests that moved the shifter
	int unsigned burst_left = 0;
	int unsigned requests_used = 0;

	spi_master_byte_shifter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.tx_byte       (tx_byte),
		.last_byte     (last_byte),
		.miso_level    (miso_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sck_level     (sck_level),
		.mosi_level    (mosi_level),
		.rx_byte       (rx_byte),
		.rx_valid      (rx_valid),
		.transfer_done (transfer_done),
		.busy_res      (busy_res),
		.rejected      (rejected)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one request: wait out any burst gap, present it on the falling edge,
	// hold it until a rising edge sees valid and ready together
	task automatic send_request(cmd_t cmd, logic [BYTE_W-1:0] tx, logic last, logic miso);
		int unsigned gap;
		req_t        req;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			// a quarter of the bursts follow the previous one back to back
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid   = 1'b1;
		command    = cmd;
		tx_byte    = tx;
		last_byte  = last;
		miso_level = miso;
		do
			@(posedge clk);
		while (!in_ready);
		req.command    = cmd;
		req.tx_byte    = tx;
		req.last_byte  = last;
		req.miso_level = miso;
		requests_used += tracker.note_request(req);
	endtask

	// register write, only issued with no request outstanding
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do
			@(posedge clk);
		while (!cfg_ready);
		tracker.apply_config(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// stop sending and let every outstanding result come back
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		burst_left = 0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one word: a load, then ticks until the shifter goes idle; now and then
	// a stray load lands mid-word, and some words are abandoned part way so
	// the next config write hits a word in flight
	task automatic run_word();
		int unsigned cut;
		int unsigned n;
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3))
				send_request(CMD_TICK, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
		send_request(CMD_LOAD, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
		cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 32'hFFFF_FFFF;
		n = 0;
		while (tracker.shifting() && n < cut) begin
			if ($urandom_range(0, 15) == 0)
				send_request(CMD_LOAD, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
			else
				send_request(CMD_TICK, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
			n++;
		end
	endtask

	// result sink: ready follows a 16-bit stall pattern, which is re-rolled;
	// a quarter of the rolls give no stalls at all
	initial begin : result_sink
		logic [15:0] stall_pattern;
		int unsigned beat;
		out_ready     = 1'b0;
		stall_pattern = 16'hFFFF;
		beat          = 0;
		forever begin
			@(negedge clk);
			if (beat % 64 == 0) begin
				if ($urandom_range(0, 3) == 0)
					stall_pattern = 16'hFFFF;
				else
					stall_pattern = 16'($urandom) | 16'h0001;
			end
			out_ready = stall_pattern[beat % 16];
			beat++;
		end
	end

	// every accepted result is checked against the oldest prediction
	always @(posedge clk) begin : result_monitor
		res_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.sck_level     = sck_level;
			seen.mosi_level    = mosi_level;
			seen.rx_byte       = rx_byte;
			seen.rx_valid      = rx_valid;
			seen.transfer_done = transfer_done;
			seen.busy_res      = busy_res;
			seen.rejected      = rejected;
			tracker.check_result(seen);
		end
	end

	initial begin : stimulus
		int unsigned n;
		int unsigned hp;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		command    = CMD_TICK;
		tx_byte    = '0;
		last_byte  = 1'b0;
		miso_level = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// tick while idle in mode 0: sck stays low, nothing moves
		send_request(CMD_TICK, 8'h00, 1'b0, 1'b1);
		settle();

		// mode 3, lsb first, longest half period; idle sck goes high
		write_reg(REG_SPI_MODE, 16'hFFFF);
		write_reg(REG_LSB_FIRST, 16'hFFFF);
		write_reg(REG_HALF_PERIOD, 16'hFFFF);
		send_request(CMD_TICK, 8'hFF, 1'b1, 1'b0);
		send_request(CMD_LOAD, 8'hFF, 1'b1, 1'b1);
		// load while busy must be rejected with no effect
		send_request(CMD_LOAD, 8'h00, 1'b0, 1'b0);
		repeat (3) send_request(CMD_TICK, 8'h00, 1'b0, 1'b1);
		settle();

		// mid-word: shorten the half period below the running count, switch
		// mode and bit order, poke the unused index
		write_reg(REG_HALF_PERIOD, 16'h0001);
		write_reg(REG_SPI_MODE, 16'h0002);
		write_reg(REG_LSB_FIRST, 16'h0000);
		write_reg(REG_UNUSED, 16'hFFFF);
		n = 0;
		while (tracker.shifting()) begin
			send_request(CMD_TICK, 8'h00, 1'b0, n[0]);
			n++;
		end
		// mosi holds its last bit once the word is done
		send_request(CMD_TICK, 8'h00, 1'b0, 1'b1);
		settle();

		// random phases: fresh settings, then a few words under them
		requests_used = 0;
		while (requests_used < RANDOM_REQUESTS) begin
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_SPI_MODE, CFG_DATA_W'($urandom_range(0, 65535)));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_LSB_FIRST, CFG_DATA_W'($urandom_range(0, 65535)));
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2: hp = 0;
					3, 4, 5: hp = 1;
					6, 7:    hp = $urandom_range(2, 3);
					default: hp = $urandom_range(4, 8);
				endcase
				write_reg(REG_HALF_PERIOD, CFG_DATA_W'(hp));
			end
			repeat ($urandom_range(1, 4)) run_word();
			settle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		tracker.close_out();
		if (tracker.failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin : watchdog
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
